@@ hdl/atg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atg_pkg
// shared types, constants and float helpers of the arange tile generator
// ----------------------------------------------------------------------------
package atg_pkg;

  localparam int unsigned ElementsPerTileDef = 32;
  localparam int unsigned PosW = 5;
  localparam int unsigned QueueDepth = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_STEP   = 2'd1;
  localparam logic [1:0] CFG_FORMAT = 2'd2;
  localparam logic [1:0] CFG_EBYTES = 2'd3;

  // output formats
  localparam logic [1:0] FMT_BF16  = 2'd0;
  localparam logic [1:0] FMT_INT32 = 2'd1;
  localparam logic [1:0] FMT_FP32  = 2'd2;

  localparam logic [31:0] START_RST  = 32'h0000_0000;
  localparam logic [31:0] STEP_RST   = 32'h3F80_0000;
  localparam logic [1:0]  FORMAT_RST = FMT_FP32;
  localparam logic [3:0]  EBYTES_RST = 4'd4;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [15:0] QNAN16 = 16'h7FC0;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_ZERO,
    KIND_INF,
    KIND_NAN
  } kind_e;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] offset;
  } job_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [31:0]     offset;
    logic            last;
  } side_t;

  typedef struct packed {
    logic               sgn;
    logic signed [12:0] e;
    logic [23:0]        m;
  } fp_t;

  // leading zero count, 64 when all zero
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] c;
    logic       found;
    c = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        c = 7'(63 - i);
        found = 1'b1;
      end
    end
    return c;
  endfunction

  // value = m * 2^(e-23)
  function automatic fp_t unpack(input logic [31:0] f);
    fp_t r;
    r.sgn = f[31];
    r.m   = {(f[30:23] != 8'd0), f[22:0]};
    r.e   = (f[30:23] == 8'd0) ? -13'sd126 : 13'(signed'({5'd0, f[30:23]})) - 13'sd127;
    return r;
  endfunction

  // normalized n (leading one at bit 63) with biased exponent be, rounded to nearest even
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [12:0] be,
                                             input logic [63:0] n);
    logic [63:0] n2;
    logic [12:0] amt;
    logic        stk;
    logic [7:0]  expb;
    logic [23:0] mant;
    logic        g;
    logic        s;
    logic        inc;
    logic [31:0] word;
    logic [31:0] res;
    n2 = n;
    stk = 1'b0;
    expb = 8'd0;
    amt = 13'd0;
    if (be < 13'sd1) begin
      // subnormal result
      amt = 13'(13'sd1 - be);
      if (amt >= 13'd64) begin
        n2 = 64'd0;
        stk = |n;
      end else begin
        n2 = n >> amt[5:0];
        stk = |(n & ~({64{1'b1}} << amt[5:0]));
      end
    end else begin
      expb = be[7:0] - 8'd1;
    end
    mant = n2[63:40];
    g = n2[39];
    s = (|n2[38:0]) | stk;
    inc = g & (s | mant[0]);
    word = {1'b0, expb, 23'd0} + {8'd0, mant} + {31'd0, inc};
    if (n == 64'd0) begin
      res = {sgn, 31'd0};
    end else if (be >= 13'sd255) begin
      res = {sgn, 8'hFF, 23'd0};
    end else begin
      res = {sgn, word[30:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] pack_kind(input kind_e k, input logic sgn,
                                            input logic signed [12:0] be, input logic [63:0] n);
    logic [31:0] r;
    unique case (k)
      KIND_NUM:  r = round_pack(sgn, be, n);
      KIND_ZERO: r = {sgn, 31'd0};
      KIND_INF:  r = {sgn, 8'hFF, 23'd0};
      KIND_NAN:  r = QNAN32;
      default:   r = QNAN32;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] encode(input logic [1:0] fmt, input logic [31:0] f);
    logic        nan;
    logic [7:0]  e;
    logic [31:0] m32;
    logic [31:0] mag;
    logic [31:0] ival;
    logic [31:0] r;
    nan = (&f[30:23]) && (|f[22:0]);
    e = f[30:23];
    m32 = {8'd0, 1'b1, f[22:0]};
    mag = 32'd0;
    if (e >= 8'd150) begin
      mag = m32 << 3'(e - 8'd150);
    end else if (e >= 8'd127) begin
      mag = m32 >> 5'(8'd150 - e);
    end
    if (nan) begin
      ival = 32'd0;
    end else if (e >= 8'd158) begin
      ival = f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      ival = f[31] ? (~mag + 32'd1) : mag;
    end
    unique case (fmt)
      FMT_BF16:  r = {16'd0, nan ? QNAN16 : f[31:16]};
      FMT_INT32: r = ival;
      FMT_FP32:  r = nan ? QNAN32 : f;
      default:   r = nan ? QNAN32 : f;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/atg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atg_front
// takes tile requests, works out element base index and byte offset
// ----------------------------------------------------------------------------
module atg_front #(
  parameter int unsigned ELEMENTS_PER_TILE = atg_pkg::ElementsPerTileDef
) (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [25:0]   tile_index_i,
  input  logic [3:0]    element_bytes_i,
  output logic          push_o,
  output atg_pkg::job_t job_o,
  input  logic          full_i
);
  import atg_pkg::*;

  logic [31:0] base;

  assign base       = 32'({6'd0, tile_index_i} * 32'(ELEMENTS_PER_TILE));
  assign job_o.base   = base;
  assign job_o.offset = 32'(base * {28'd0, element_bytes_i});
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

@@ hdl/atg_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atg_queue
// short queue of tile jobs between front and back
// ----------------------------------------------------------------------------
module atg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  atg_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output atg_pkg::job_t job_o
);
  import atg_pkg::*;

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  job_t          mem_q [QueueDepth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(QueueDepth - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(QueueDepth - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

@@ hdl/atg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atg_back
// element sequencer and float pipeline: convert, multiply, add, encode
// ----------------------------------------------------------------------------
module atg_back #(
  parameter int unsigned ELEMENTS_PER_TILE = atg_pkg::ElementsPerTileDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  input  atg_pkg::job_t            job_i,
  output logic                     job_pop_o,
  input  logic [31:0]              start_bits_i,
  input  logic [31:0]              step_bits_i,
  input  logic [1:0]               fmt_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [31:0]              element_value_o,
  output logic [atg_pkg::PosW-1:0] element_position_o,
  output logic [31:0]              byte_offset_o,
  output logic                     last_o
);
  import atg_pkg::*;

  localparam int unsigned WW = (ELEMENTS_PER_TILE > 1) ? $clog2(ELEMENTS_PER_TILE) : 1;

  logic          en, issue, w_last;
  logic [WW-1:0] w_q, w_d;

  // stage registers
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, vo_q;
  side_t sd1_q, sd2_q, sd3_q, sd4_q, sd5_q, sd6_q, sd7_q, sd8_q, sdo_q;
  logic [31:0] idx1_q;
  logic [63:0] n2_q, n5_q, n8_q;
  logic signed [12:0] be2_q, be5_q, be8_q;
  logic sgn2_q, sgn4_q, sgn5_q, sgn7_q, sgn8_q;
  logic [31:0] x3_q, prod6_q, val_q;
  logic [47:0] p4_q;
  logic signed [12:0] e4_q, el7_q;
  kind_e k4_q, k5_q, k7_q, k8_q;
  logic [50:0] sum7_q;

  // conversion
  logic [31:0] mag;
  logic [63:0] c_n0;
  logic [6:0]  c_lz;

  // multiply
  fp_t  ua, ub;
  logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  kind_e m_kind;

  logic [63:0] m_n0;
  logic [6:0]  m_lz;

  // add
  fp_t  pa, pb, fl, fs;
  logic pa_nan, pa_inf, pb_nan, pb_inf, swap, sub, stk;
  logic [12:0] d;
  logic [49:0] big, sm, al;
  logic [50:0] sum;
  kind_e a_kind;
  logic a_sgn;

  logic [63:0] s_n0;
  logic [6:0]  s_lz;

  assign en        = !vo_q || !out_stall_i;
  assign w_last    = (w_q == WW'(ELEMENTS_PER_TILE - 1));
  assign issue     = job_valid_i && en;
  assign job_pop_o = issue && w_last;

  always_comb begin
    w_d = w_q;
    if (issue) begin
      w_d = w_last ? '0 : w_q + WW'(1);
    end
  end

  // convert index to float
  assign mag  = idx1_q[31] ? (~idx1_q + 32'd1) : idx1_q;
  assign c_n0 = {mag, 32'd0};
  assign c_lz = lzc64(c_n0);

  // multiply step by index
  always_comb begin
    ua = unpack(step_bits_i);
    ub = unpack(x3_q);
    a_nan  = (&step_bits_i[30:23]) && (|step_bits_i[22:0]);
    a_inf  = (&step_bits_i[30:23]) && !(|step_bits_i[22:0]);
    a_zero = (step_bits_i[30:0] == 31'd0);
    b_nan  = (&x3_q[30:23]) && (|x3_q[22:0]);
    b_inf  = (&x3_q[30:23]) && !(|x3_q[22:0]);
    b_zero = (x3_q[30:0] == 31'd0);
    priority if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      m_kind = KIND_NAN;
    end else if (a_inf || b_inf) begin
      m_kind = KIND_INF;
    end else if (a_zero || b_zero) begin
      m_kind = KIND_ZERO;
    end else begin
      m_kind = KIND_NUM;
    end
  end

  assign m_n0 = {p4_q, 16'd0};
  assign m_lz = lzc64(m_n0);

  // add start
  always_comb begin
    pa = unpack(prod6_q);
    pb = unpack(start_bits_i);
    pa_nan = (&prod6_q[30:23]) && (|prod6_q[22:0]);
    pa_inf = (&prod6_q[30:23]) && !(|prod6_q[22:0]);
    pb_nan = (&start_bits_i[30:23]) && (|start_bits_i[22:0]);
    pb_inf = (&start_bits_i[30:23]) && !(|start_bits_i[22:0]);
    swap = (start_bits_i[30:0] > prod6_q[30:0]);
    fl = swap ? pb : pa;
    fs = swap ? pa : pb;
    sub = fl.sgn ^ fs.sgn;
    d = 13'(fl.e - fs.e);
    big = {fl.m, 26'd0};
    sm  = {fs.m, 26'd0};
    if (d >= 13'd50) begin
      al = 50'd0;
      stk = |fs.m;
    end else begin
      al = sm >> d[5:0];
      stk = |(sm & ~({50{1'b1}} << d[5:0]));
    end
    al[0] = al[0] | stk;
    sum = sub ? ({1'b0, big} - {1'b0, al}) : ({1'b0, big} + {1'b0, al});
    a_sgn = fl.sgn;
    priority if (pa_nan || pb_nan || (pa_inf && pb_inf && sub)) begin
      a_kind = KIND_NAN;
    end else if (pa_inf || pb_inf) begin
      a_kind = KIND_INF;
      a_sgn = pa_inf ? pa.sgn : pb.sgn;
    end else if (sum == 51'd0) begin
      a_kind = KIND_ZERO;
      a_sgn = sub ? 1'b0 : fl.sgn;
    end else begin
      a_kind = KIND_NUM;
    end
  end

  assign s_n0 = {sum7_q, 13'd0};
  assign s_lz = lzc64(s_n0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      w_q <= w_d;
      if (en) begin
        v1_q <= issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
        v6_q <= v5_q;
        v7_q <= v6_q;
        v8_q <= v7_q;
        vo_q <= v8_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q <= job_i.base + 32'(w_q);
      sd1_q <= '{pos: PosW'(w_q), offset: job_i.offset, last: w_last};

      n2_q <= c_n0 << c_lz;
      be2_q <= 13'sd158 - 13'(signed'({6'd0, c_lz}));
      sgn2_q <= idx1_q[31];
      sd2_q <= sd1_q;

      x3_q <= round_pack(sgn2_q, be2_q, n2_q);
      sd3_q <= sd2_q;

      p4_q <= ua.m * ub.m;
      e4_q <= ua.e + ub.e;
      sgn4_q <= step_bits_i[31] ^ x3_q[31];
      k4_q <= m_kind;
      sd4_q <= sd3_q;

      n5_q <= m_n0 << m_lz;
      be5_q <= e4_q + 13'sd128 - 13'(signed'({6'd0, m_lz}));
      sgn5_q <= sgn4_q;
      k5_q <= k4_q;
      sd5_q <= sd4_q;

      prod6_q <= pack_kind(k5_q, sgn5_q, be5_q, n5_q);
      sd6_q <= sd5_q;

      sum7_q <= sum;
      el7_q <= fl.e;
      sgn7_q <= a_sgn;
      k7_q <= a_kind;
      sd7_q <= sd6_q;

      n8_q <= s_n0 << s_lz;
      be8_q <= el7_q + 13'sd128 - 13'(signed'({6'd0, s_lz}));
      sgn8_q <= sgn7_q;
      k8_q <= k7_q;
      sd8_q <= sd7_q;

      val_q <= encode(fmt_i, pack_kind(k8_q, sgn8_q, be8_q, n8_q));
      sdo_q <= sd8_q;
    end
  end

  assign out_valid_o        = vo_q;
  assign element_value_o    = val_q;
  assign element_position_o = sdo_q.pos;
  assign byte_offset_o      = sdo_q.offset;
  assign last_o             = sdo_q.last;

endmodule

@@ hdl/arange_tile_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arange_tile_generator_unit
// emits the elements of one arange tile per request: step * index + start
// ----------------------------------------------------------------------------
// throughput: one element per cycle while the output is not stalled, set by
//   the single element sequencer feeding the nine-stage float pipeline
// a two-entry job queue lets new tiles be taken while results wait
// reset: asynchronous, active low; clears queue, sequencer, pipeline valids and
//   loads the register defaults (start 0.0, step 1.0, float32, 4 bytes)
module arange_tile_generator_unit #(
  parameter int unsigned ELEMENTS_PER_TILE = atg_pkg::ElementsPerTileDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [31:0]              cfg_data_i,
  // tile request channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [25:0]              tile_index_i,
  // element channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [31:0]              element_value_o,
  output logic [atg_pkg::PosW-1:0] element_position_o,
  output logic [31:0]              byte_offset_o,
  output logic                     last_o
);
  import atg_pkg::*;

  // configuration registers
  logic [31:0] start_q, step_q;
  logic [1:0]  fmt_q;
  logic [3:0]  ebytes_q;

  // front to queue
  logic push, full;
  job_t job_in;

  // queue to back
  logic job_valid, job_pop;
  job_t job_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RST;
      step_q <= STEP_RST;
      fmt_q <= FORMAT_RST;
      ebytes_q <= EBYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START:  start_q <= cfg_data_i;
        CFG_STEP:   step_q <= cfg_data_i;
        CFG_FORMAT: fmt_q <= cfg_data_i[1:0];
        CFG_EBYTES: ebytes_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // front: request transfer, base index and byte offset of the tile
  atg_front #(
    .ELEMENTS_PER_TILE(ELEMENTS_PER_TILE)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .tile_index_i   (tile_index_i),
    .element_bytes_i(ebytes_q),
    .push_o         (push),
    .job_o          (job_in),
    .full_i         (full)
  );

  // decouples the request side from the element stream
  atg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .job_o  (job_head)
  );

  // back: walks the elements of the head job through the float pipeline
  atg_back #(
    .ELEMENTS_PER_TILE(ELEMENTS_PER_TILE)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (job_valid),
    .job_i             (job_head),
    .job_pop_o         (job_pop),
    .start_bits_i      (start_q),
    .step_bits_i       (step_q),
    .fmt_i             (fmt_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .element_value_o   (element_value_o),
    .element_position_o(element_position_o),
    .byte_offset_o     (byte_offset_o),
    .last_o            (last_o)
  );

endmodule

@@ hdl/atg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atg_checker
// port-level checks of the element stream, bound to the top level
// ----------------------------------------------------------------------------
module atg_checker #(
  parameter int unsigned ELEMENTS_PER_TILE = atg_pkg::ElementsPerTileDef
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [31:0]              element_value_o,
  input logic [atg_pkg::PosW-1:0] element_position_o,
  input logic [31:0]              byte_offset_o,
  input logic                     last_o
);
  import atg_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid_o && !out_stall_i;

  // stalled element holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_value_o))
    else $error("stalled element changed");

  // positions count up within a tile
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_o |=> !out_valid_o ||
      element_position_o == $past(element_position_o) + PosW'(1))
    else $error("element position out of order");

  // one offset for a whole tile
  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_o |=> !out_valid_o || byte_offset_o == $past(byte_offset_o))
    else $error("byte offset changed inside a tile");

  // last flag only on the final position
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> element_position_o == PosW'(ELEMENTS_PER_TILE - 1))
    else $error("last flag on wrong position");

  // a tile starts at position zero
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && last_o |=> !out_valid_o || element_position_o == PosW'(0))
    else $error("tile does not start at position zero");

endmodule

bind arange_tile_generator_unit atg_checker #(
  .ELEMENTS_PER_TILE(ELEMENTS_PER_TILE)
) u_atg_checker (.*);

@@ dv/arange_tile_generator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arange_tile_generator_unit_tb
// self-checking bench: tile requests go in with random gaps, element transfers
// come out under random stalls and are checked against a single-precision
// model of step * index + start, output encodings and byte offsets
// ----------------------------------------------------------------------------
module arange_tile_generator_unit_tb;
  import atg_pkg::*;

  localparam int unsigned Tile = 32;
  localparam int unsigned DrainCycles = 40;

  typedef struct {
    logic [31:0]     value;
    logic [PosW-1:0] pos;
    logic [31:0]     offset;
    logic            last;
  } element_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [31:0]         cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [25:0]         tile_index_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [31:0]         element_value_o;
  logic [PosW-1:0]     element_position_o;
  logic [31:0]         byte_offset_o;
  logic                last_o;

  arange_tile_generator_unit #(.ELEMENTS_PER_TILE(Tile)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .tile_index_i,
    .out_valid_o, .out_stall_i, .element_value_o, .element_position_o,
    .byte_offset_o, .last_o
  );

  // shadow copy of the register file
  logic [31:0] start_q;
  logic [31:0] step_q;
  logic [1:0]  format_q;
  logic [3:0]  ebytes_q;

  element_t pending_elements[$];
  int       errors;
  bit       no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // single-precision arithmetic on top of doubles: a product of two floats is
  // exact in double, and rounding a double sum to float gives the correctly
  // rounded float sum, so one rounding step per operation is bit exact
  // ---------------------------------------------------------------------------
  function automatic real sp_to_real(input logic [31:0] f);
    logic [63:0] d;
    if (f[30:23] == 8'd0) begin
      // subnormal or zero: m * 2^-149
      return (f[31] ? -1.0 : 1.0) * real'(f[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
    end
    if (f[30:23] == 8'hFF) d = {f[31], 11'h7FF, f[22:0], 29'd0};
    else d = {f[31], 11'({3'd0, f[30:23]} + 11'd896), f[22:0], 29'd0};
    return $bitstoreal(d);
  endfunction

  // round a double to single precision, nearest even
  function automatic logic [31:0] real_to_sp(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] w;
    int          fe;
    int          ef;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (|d[51:0]) ? QNAN32 : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    fe = int'(d[62:52]) - 896;
    ef = (fe < 1) ? 1 : fe;
    sh = 29 + ef - fe;
    if (sh > 63) return {d[63], 31'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    kept = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    // hidden bit in kept lifts the exponent field by one, hence ef - 1
    w = (64'(ef - 1) << 23) + kept + 64'((rem > half) || (rem == half && kept[0]));
    if (w >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
    return {d[63], w[30:0]};
  endfunction

  function automatic logic [31:0] encode_element(input logic [1:0] fmt, input logic [31:0] v);
    logic nan;
    real  vr;
    nan = (&v[30:23]) && (|v[22:0]);
    vr = sp_to_real(v);
    case (fmt)
      FMT_BF16:  return {16'd0, nan ? QNAN16 : v[31:16]};
      FMT_INT32: begin
        if (nan) return 32'd0;
        if (vr >= 2147483648.0) return 32'h7FFF_FFFF;
        if (vr <= -2147483648.0) return 32'h8000_0000;
        return 32'($rtoi(vr));
      end
      default:   return nan ? QNAN32 : v;
    endcase
  endfunction

  // expected elements of one tile, appended to the queue
  task automatic predict_tile(input logic [25:0] tile);
    logic [31:0] base;
    logic [31:0] idx;
    logic [31:0] x;
    logic [31:0] prod;
    logic [31:0] val;
    element_t    e;
    base = {1'b0, tile, 5'd0};
    for (int w = 0; w < Tile; w++) begin
      idx = base + 32'(w);
      x = real_to_sp(real'($signed(idx)));
      prod = real_to_sp(sp_to_real(step_q) * sp_to_real(x));
      val = real_to_sp(sp_to_real(prod) + sp_to_real(start_q));
      e.value = encode_element(format_q, val);
      e.pos = PosW'(w);
      e.offset = base * {28'd0, ebytes_q};
      e.last = (w == Tile - 1);
      pending_elements.push_back(e);
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // tile request side; valid stays high between back-to-back transfers
  // ---------------------------------------------------------------------------
  task automatic send_tile(input logic [25:0] tile);
    int  gap;
    bit  taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tile_index_i <= tile;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_tile(tile);
  endtask

  // block idle: every expected element seen, then a latency margin
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_elements.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START:  start_q = data;
      CFG_STEP:   step_q = data;
      CFG_FORMAT: format_q = data[1:0];
      default:    ebytes_q = data[3:0];
    endcase
  endtask

  task automatic set_all(input logic [31:0] start, input logic [31:0] step,
                         input logic [1:0] fmt, input logic [3:0] eb);
    drain();
    write_reg(CFG_START, start);
    write_reg(CFG_STEP, step);
    write_reg(CFG_FORMAT, {30'd0, fmt});
    write_reg(CFG_EBYTES, {28'd0, eb});
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register defaults straight out of reset, smallest and largest tile
  task automatic test_defaults();
    send_tile(26'd0);
    send_tile(26'd1);
    send_tile(26'h3FF_FFFF);
  endtask

  // every format code, including the unused one, on a fractional ramp
  task automatic test_formats();
    for (int f = 0; f < 4; f++) begin
      set_all(32'hC47A_2000, 32'h3E80_0000, f[1:0], 4'd2);
      send_tile(26'd0);
      send_tile(26'd1000);
    end
  endtask

  // nan and inf inputs, overflow, subnormals, int32 saturation, odd element sizes
  task automatic test_special_values();
    set_all(32'h7FC0_0001, 32'h3F80_0000, FMT_FP32, 4'd0);   // nan start
    send_tile(26'd5);
    set_all(32'h0000_0000, 32'h7F80_0000, FMT_BF16, 4'd15);  // inf step, 0 * inf
    send_tile(26'd0);
    set_all(32'hFF7F_FFFF, 32'h7F7F_FFFF, FMT_FP32, 4'd8);   // overflow to inf
    send_tile(26'd3);
    set_all(32'h8000_0001, 32'h0000_0001, FMT_FP32, 4'd1);   // subnormal results
    send_tile(26'd0);
    send_tile(26'h3FF_FFFF);
    set_all(32'h4F00_0000, 32'h501502F9, FMT_INT32, 4'd9);   // saturate high
    send_tile(26'h3FF_FFFF);
    set_all(32'hCF00_0000, 32'hD01502F9, FMT_INT32, 4'd7);   // saturate low
    send_tile(26'd1);
    set_all(32'h7FFF_FFFF, 32'h3F80_0000, FMT_INT32, 4'd4);  // nan to int 0
    send_tile(26'd2);
    set_all(32'h3F00_0000, 32'hBF80_0000, FMT_INT32, 4'd3);  // truncation toward zero
    send_tile(26'd0);
  endtask

  function automatic logic [31:0] random_float();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 160)), 23'($urandom())};
      2:       return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 132)), 23'd0};
      default: return {1'b0, 8'($urandom_range(127, 130)), 23'($urandom()) & 23'h7F0000};
    endcase
  endfunction

  // random settings per phase, random tiles, three phases without gaps
  task automatic test_random_tiles();
    logic [25:0] tile;
    for (int ph = 0; ph < 16; ph++) begin
      set_all(random_float(), random_float(), 2'($urandom_range(0, 3)),
              4'($urandom_range(0, 15)));
      no_gaps = (ph % 5 == 2);
      for (int n = 0; n < 19; n++) begin
        case ($urandom_range(0, 3))
          0:       tile = 26'($urandom_range(0, 63));
          1:       tile = 26'h3FF_FFFF - 26'($urandom_range(0, 63));
          default: tile = 26'($urandom());
        endcase
        send_tile(tile);
      end
      no_gaps = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // element side: random stalls, with quiet stretches and a few long holds
  // ---------------------------------------------------------------------------
  initial begin
    bit quiet;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk_i);
        out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  // compare each transfer with the oldest expected element
  always @(negedge clk_i) begin
    element_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_elements.size() == 0) begin
        $display("%0t: unexpected element transfer value %h", $time, element_value_o);
        errors++;
      end else begin
        e = pending_elements.pop_front();
        if (element_value_o !== e.value) begin
          $display("%0t: element_value expected %h actual %h", $time, e.value,
                   element_value_o);
          errors++;
        end
        if (element_position_o !== e.pos) begin
          $display("%0t: element_position expected %0d actual %0d", $time, e.pos,
                   element_position_o);
          errors++;
        end
        if (byte_offset_o !== e.offset) begin
          $display("%0t: byte_offset expected %h actual %h", $time, e.offset,
                   byte_offset_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, last_o);
          errors++;
        end
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    errors = 0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_START;
    cfg_data_i = 32'd0;
    in_valid_i = 1'b0;
    tile_index_i = 26'd0;
    start_q = START_RST;
    step_q = STEP_RST;
    format_q = FORMAT_RST;
    ebytes_q = EBYTES_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_formats();
    test_special_values();
    test_random_tiles();
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
